/* src/gvbs_pkg.sv */
// ----------------------------------------------------------------------------
// gvbs_pkg - shared types and constants of the gc victim block selector
// Selection modes, register indexes, sequencer states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gvbs_pkg;

  // field widths
  localparam int ID_W    = 32;
  localparam int PAGE_W  = 16;
  localparam int READ_W  = 32;
  localparam int TICK_W  = 64;
  localparam int VPOS_W  = 10;
  localparam int MODE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int WIDE_W  = MUL_W + TICK_W;

  // default list capacity
  localparam int DEF_MAX_BLOCKS = 1024;

  // register indexes (word index taken from paddr[2])
  localparam logic REG_SELECT_MODE = 1'b0;
  localparam logic REG_PAGE_COUNT  = 1'b1;

  // selection modes
  typedef enum logic [MODE_W-1:0] {
    MODE_GREEDY       = 3'd0,
    MODE_COST_BENEFIT = 3'd1,
    MODE_FIRST        = 3'd2,
    MODE_LEAST_READ   = 3'd3,
    MODE_LAST         = 3'd4,
    MODE_MOST_READ    = 3'd5,
    MODE_OLDEST       = 3'd6,
    MODE_NEWEST       = 3'd7
  } sel_mode_t;

  localparam sel_mode_t           RESET_MODE       = MODE_GREEDY;
  localparam logic [PAGE_W-1:0]   RESET_PAGE_COUNT = 16'd256;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_L,
    ST_MUL_R,
    ST_MUL_L0,
    ST_MUL_L1,
    ST_MUL_R0,
    ST_MUL_R1,
    ST_ACC,
    ST_CMP,
    ST_FINISH
  } seq_state_t;

  // settings handed from the register file to the scan logic
  typedef struct packed {
    sel_mode_t            mode;
    logic [PAGE_W-1:0]    page_count;
    logic                 restart;
  } cfg_t;

  // starting key of the running best for each mode
  function automatic logic [TICK_W-1:0] init_key(input sel_mode_t mode);
    logic [TICK_W-1:0] k;
    k = '0;
    case (mode)
      MODE_GREEDY, MODE_LEAST_READ: k = {{(TICK_W-32){1'b0}}, 32'hFFFF_FFFF};
      MODE_OLDEST:                  k = '1;
      default:                      k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/gvbs_in_if.sv */
// ----------------------------------------------------------------------------
// gvbs_in_if - block metadata request channel
// Valid/ready channel carrying one list entry per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gvbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [gvbs_pkg::ID_W-1:0]     block_id;
  logic [gvbs_pkg::PAGE_W-1:0]   valid_pages;
  logic [gvbs_pkg::READ_W-1:0]   read_count;
  logic [gvbs_pkg::TICK_W-1:0]   inserted_tick;
  logic                          last_block;

  modport source (
    output valid, block_id, valid_pages, read_count, inserted_tick, last_block,
    input  ready
  );
  modport sink (
    input  valid, block_id, valid_pages, read_count, inserted_tick, last_block,
    output ready
  );
endinterface

`default_nettype wire

/* src/gvbs_out_if.sv */
// ----------------------------------------------------------------------------
// gvbs_out_if - victim result channel
// Valid/ready channel carrying the chosen victim of one list.
// ----------------------------------------------------------------------------
`default_nettype none

interface gvbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [gvbs_pkg::VPOS_W-1:0]   victim_position;
  logic [gvbs_pkg::ID_W-1:0]     victim_block;

  modport source (
    output valid, victim_position, victim_block,
    input  ready
  );
  modport sink (
    input  valid, victim_position, victim_block,
    output ready
  );
endinterface

`default_nettype wire

/* src/gc_victim_block_selector.sv */
// ----------------------------------------------------------------------------
// gc_victim_block_selector - garbage-collection victim selection
// Scans one full-block list, one block per request, keeps a running best for
// the selected mode and returns the victim after the entry marked last.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in_ch     sink       valid/ready           block_id, valid_pages, read_count,
//                                             inserted_tick, last_block
//  out_ch    source     valid/ready           victim_position, victim_block
//  apb       slave      psel/penable, pready  paddr, pwdata, prdata
//
//  a request goes through accept, evaluate and finish in every mode but
//  cost-benefit; cost-benefit against an existing finite best adds six passes
//  through the one 32x32 multiplier plus accumulate and compare.
//  after reset the block is ready at once; no memory needs clearing.
//  the last request of a list waits in finish while the previous victim is
//  still held in the output register; otherwise out_ch stalls never block input.
// ----------------------------------------------------------------------------
`default_nettype none

module gc_victim_block_selector #(
  parameter int MAX_BLOCKS = gvbs_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gvbs_in_if.sink                            in_ch,
  gvbs_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gvbs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gvbs_pkg::DATA_W-1:0]   pwdata,
  output logic      [gvbs_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int POS_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BLOCKS - 1);
  localparam int ID_W   = gvbs_pkg::ID_W;
  localparam int PAGE_W = gvbs_pkg::PAGE_W;
  localparam int READ_W = gvbs_pkg::READ_W;
  localparam int TICK_W = gvbs_pkg::TICK_W;
  localparam int MUL_W  = gvbs_pkg::MUL_W;
  localparam int PROD_W = gvbs_pkg::PROD_W;
  localparam int WIDE_W = gvbs_pkg::WIDE_W;
  localparam int VPOS_W = gvbs_pkg::VPOS_W;

  gvbs_pkg::cfg_t        cfg;
  gvbs_pkg::seq_state_t  state_r, state_nxt;

  // request held during evaluation
  logic [ID_W-1:0]       id_r;
  logic [PAGE_W-1:0]     vld_r;
  logic [READ_W-1:0]     reads_r;
  logic [TICK_W-1:0]     tick_r;
  logic                  last_r;

  // scan state
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      best_pos_r;
  logic [ID_W-1:0]       best_id_r;
  logic [TICK_W-1:0]     best_key_r;
  logic [PAGE_W-1:0]     best_valid_r;
  logic [TICK_W-1:0]     best_tick_r;
  logic                  best_finite_r;

  // cross-multiplication
  logic [MUL_W-1:0]      left_r;
  logic [MUL_W-1:0]      right_r;
  logic [WIDE_W-1:0]     lprod_r;
  logic [WIDE_W-1:0]     rprod_r;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [PROD_W-1:0]     prod_r;

  // output register
  logic                  out_valid_r;
  logic [VPOS_W-1:0]     out_pos_r;
  logic [ID_W-1:0]       out_id_r;

  logic                  accept;
  logic                  out_busy;
  logic                  load_out;
  logic                  take;
  logic                  take_simple;
  logic                  cb_denom_ok;
  logic                  cb_mode;
  logic [TICK_W-1:0]     key;
  logic                  key_lt;
  logic                  key_eq;
  logic [PAGE_W-1:0]     clamp_valid;
  logic [POS_W+VPOS_W-1:0] best_pos_ext;

  gvbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gvbs_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // handshake
  assign in_ch.ready = (state_r == gvbs_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid_r && !out_ch.ready;
  assign load_out    = (state_r == gvbs_pkg::ST_FINISH) && last_r && !out_busy;
  assign cb_mode     = (cfg.mode == gvbs_pkg::MODE_COST_BENEFIT);
  assign clamp_valid = (in_ch.valid_pages > cfg.page_count) ? cfg.page_count
                                                             : in_ch.valid_pages;
  assign cb_denom_ok = (vld_r != cfg.page_count) && (tick_r != '0);

  // key of the current request for the compare modes
  always_comb begin
    case (cfg.mode)
      gvbs_pkg::MODE_GREEDY:     key = {{(TICK_W-PAGE_W){1'b0}}, vld_r};
      gvbs_pkg::MODE_LEAST_READ,
      gvbs_pkg::MODE_MOST_READ:  key = {{(TICK_W-READ_W){1'b0}}, reads_r};
      gvbs_pkg::MODE_OLDEST,
      gvbs_pkg::MODE_NEWEST:     key = tick_r;
      default:                   key = '0;
    endcase
  end

  assign key_lt = key < best_key_r;
  assign key_eq = key == best_key_r;

  // take decision of the single-compare modes
  always_comb begin
    case (cfg.mode)
      gvbs_pkg::MODE_GREEDY,
      gvbs_pkg::MODE_LEAST_READ,
      gvbs_pkg::MODE_OLDEST:     take_simple = key_lt;
      gvbs_pkg::MODE_MOST_READ,
      gvbs_pkg::MODE_NEWEST:     take_simple = !key_lt && !key_eq;
      gvbs_pkg::MODE_LAST:       take_simple = 1'b1;
      default:                   take_simple = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gvbs_pkg::ST_IDLE:   if (accept) state_nxt = gvbs_pkg::ST_EVAL;
      gvbs_pkg::ST_EVAL: begin
        if (cb_mode && cb_denom_ok && best_finite_r) state_nxt = gvbs_pkg::ST_MUL_L;
        else state_nxt = gvbs_pkg::ST_FINISH;
      end
      gvbs_pkg::ST_MUL_L:  state_nxt = gvbs_pkg::ST_MUL_R;
      gvbs_pkg::ST_MUL_R:  state_nxt = gvbs_pkg::ST_MUL_L0;
      gvbs_pkg::ST_MUL_L0: state_nxt = gvbs_pkg::ST_MUL_L1;
      gvbs_pkg::ST_MUL_L1: state_nxt = gvbs_pkg::ST_MUL_R0;
      gvbs_pkg::ST_MUL_R0: state_nxt = gvbs_pkg::ST_MUL_R1;
      gvbs_pkg::ST_MUL_R1: state_nxt = gvbs_pkg::ST_ACC;
      gvbs_pkg::ST_ACC:    state_nxt = gvbs_pkg::ST_CMP;
      gvbs_pkg::ST_CMP:    state_nxt = gvbs_pkg::ST_FINISH;
      gvbs_pkg::ST_FINISH: if (!last_r || !out_busy) state_nxt = gvbs_pkg::ST_IDLE;
      default:             state_nxt = gvbs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: multiplier operands and take strobe
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    take  = 1'b0;
    case (state_r)
      gvbs_pkg::ST_EVAL: begin
        if (cb_mode) take = cb_denom_ok && !best_finite_r;
        else         take = take_simple;
      end
      gvbs_pkg::ST_MUL_L: begin
        mul_a = {{(MUL_W-PAGE_W){1'b0}}, vld_r};
        mul_b = {{(MUL_W-PAGE_W){1'b0}}, cfg.page_count - best_valid_r};
      end
      gvbs_pkg::ST_MUL_R: begin
        mul_a = {{(MUL_W-PAGE_W){1'b0}}, best_valid_r};
        mul_b = {{(MUL_W-PAGE_W){1'b0}}, cfg.page_count - vld_r};
      end
      gvbs_pkg::ST_MUL_L0: begin
        mul_a = left_r;
        mul_b = best_tick_r[MUL_W-1:0];
      end
      gvbs_pkg::ST_MUL_L1: begin
        mul_a = left_r;
        mul_b = best_tick_r[TICK_W-1:MUL_W];
      end
      gvbs_pkg::ST_MUL_R0: begin
        mul_a = right_r;
        mul_b = tick_r[MUL_W-1:0];
      end
      gvbs_pkg::ST_MUL_R1: begin
        mul_a = right_r;
        mul_b = tick_r[TICK_W-1:MUL_W];
      end
      gvbs_pkg::ST_CMP:    take = lprod_r < rprod_r;
      default: begin
        mul_a = '0;
        mul_b = '0;
        take  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gvbs_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // capture the request, clamping valid pages to the page count
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r    <= in_ch.block_id;
      vld_r   <= clamp_valid;
      reads_r <= in_ch.read_count;
      tick_r  <= in_ch.inserted_tick;
      last_r  <= in_ch.last_block;
    end
  end

  // partial products and their accumulation
  always_ff @(posedge clk) begin
    case (state_r)
      gvbs_pkg::ST_MUL_R:  left_r  <= prod_r[MUL_W-1:0];
      gvbs_pkg::ST_MUL_L0: right_r <= prod_r[MUL_W-1:0];
      gvbs_pkg::ST_MUL_L1: lprod_r <= {{(WIDE_W-PROD_W){1'b0}}, prod_r};
      gvbs_pkg::ST_MUL_R0: lprod_r <= lprod_r + {prod_r, {MUL_W{1'b0}}};
      gvbs_pkg::ST_MUL_R1: rprod_r <= {{(WIDE_W-PROD_W){1'b0}}, prod_r};
      gvbs_pkg::ST_ACC:    rprod_r <= rprod_r + {prod_r, {MUL_W{1'b0}}};
      default: begin
        left_r <= left_r;
      end
    endcase
  end

  // running best and scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      best_pos_r    <= '0;
      best_id_r     <= '0;
      best_key_r    <= gvbs_pkg::init_key(gvbs_pkg::RESET_MODE);
      best_valid_r  <= '0;
      best_tick_r   <= '0;
      best_finite_r <= 1'b0;
    end else if (cfg.restart || load_out) begin
      pos_r         <= '0;
      best_pos_r    <= '0;
      best_id_r     <= '0;
      best_key_r    <= gvbs_pkg::init_key(cfg.mode);
      best_valid_r  <= '0;
      best_tick_r   <= '0;
      best_finite_r <= 1'b0;
    end else begin
      // the first entry of a list is the fallback victim
      if (accept && (pos_r == '0)) begin
        best_pos_r <= '0;
        best_id_r  <= in_ch.block_id;
      end
      if (take) begin
        best_pos_r    <= pos_r;
        best_id_r     <= id_r;
        best_key_r    <= cb_mode ? '0 : key;
        best_valid_r  <= vld_r;
        best_tick_r   <= tick_r;
        best_finite_r <= 1'b1;
      end
      if ((state_r == gvbs_pkg::ST_FINISH) && !last_r && (pos_r < POS_MAX)) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // output register
  assign best_pos_ext = {{VPOS_W{1'b0}}, best_pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos_r <= best_pos_ext[VPOS_W-1:0];
      out_id_r  <= best_id_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.victim_position = out_pos_r;
  assign out_ch.victim_block    = out_id_r;

  // a register write restarts the scan from the list head
  a_restart_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.restart |=> (pos_r == '0) && !best_finite_r)
    else $error("scan not restarted after register write");

  // scan position saturates at the list capacity
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("scan position beyond list capacity");

  // a victim never overwrites one that is still waiting
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");

  // the multiply sequence runs only in cost-benefit mode with a finite best
  a_mul_only_cb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gvbs_pkg::ST_MUL_L) |-> (cb_mode && best_finite_r && cb_denom_ok))
    else $error("cross-multiplication entered outside cost-benefit");

endmodule

`default_nettype wire

/* src/gvbs_cfg.sv */
// ----------------------------------------------------------------------------
// gvbs_cfg - configuration registers
// APB-style register file for select_mode and page_count, with a restart
// pulse in the cycle after any register write.
// ----------------------------------------------------------------------------
`default_nettype none

module gvbs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gvbs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [gvbs_pkg::DATA_W-1:0]   pwdata,
  output logic      [gvbs_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output gvbs_pkg::cfg_t                     cfg
);

  gvbs_pkg::sel_mode_t               mode_r, mode_nxt;
  logic [gvbs_pkg::PAGE_W-1:0]       page_r, page_nxt;
  logic                              restart_r, restart_nxt;
  logic                              wr_en;
  logic                              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    mode_nxt    = mode_r;
    page_nxt    = page_r;
    restart_nxt = 1'b0;
    if (wr_en) begin
      restart_nxt = 1'b1;
      case (reg_idx)
        gvbs_pkg::REG_SELECT_MODE: mode_nxt =
          gvbs_pkg::sel_mode_t'(pwdata[gvbs_pkg::MODE_W-1:0]);
        gvbs_pkg::REG_PAGE_COUNT:  page_nxt = pwdata[gvbs_pkg::PAGE_W-1:0];
        default:                   restart_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= gvbs_pkg::RESET_MODE;
      page_r    <= gvbs_pkg::RESET_PAGE_COUNT;
      restart_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      page_r    <= page_nxt;
      restart_r <= restart_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      gvbs_pkg::REG_SELECT_MODE:
        prdata = {{(gvbs_pkg::DATA_W-gvbs_pkg::MODE_W){1'b0}}, mode_r};
      gvbs_pkg::REG_PAGE_COUNT:
        prdata = {{(gvbs_pkg::DATA_W-gvbs_pkg::PAGE_W){1'b0}}, page_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.mode       = mode_r;
  assign cfg.page_count = page_r;
  assign cfg.restart    = restart_r;

endmodule

`default_nettype wire

/* src/gvbs_mul.sv */
// ----------------------------------------------------------------------------
// gvbs_mul - shared multiplier
// One 32x32 unsigned multiplier with a registered 64-bit product, reused for
// every partial product of the cost-benefit cross-multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module gvbs_mul (
  input  wire logic                          clk,
  input  wire logic [gvbs_pkg::MUL_W-1:0]    op_a,
  input  wire logic [gvbs_pkg::MUL_W-1:0]    op_b,
  output logic      [gvbs_pkg::PROD_W-1:0]   prod_r
);

  logic [gvbs_pkg::PROD_W-1:0] prod_nxt;

  // product, registered before any further use
  assign prod_nxt = {{gvbs_pkg::MUL_W{1'b0}}, op_a} * {{gvbs_pkg::MUL_W{1'b0}}, op_b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire
